[rtl/slgd_pkg.sv]
// ----------------------------------------------------------------------------
// slgd_pkg
// Types and constants shared by the structured-light Gray decoder.
// ----------------------------------------------------------------------------
package slgd_pkg;

	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned CODE_W   = 10;
	localparam int unsigned LIGHT_W  = 20;
	localparam int unsigned SCALE_W  = 16;
	localparam int unsigned REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_LIT_MARGIN = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_DIRECT = 1'b1;

	localparam logic [7:0] LIT_MARGIN_RST = 8'd5;
	localparam logic [7:0] MIN_DIRECT_RST = 8'd15;

	typedef struct packed {
		logic [7:0] pat_h;
		logic [7:0] pat_h_inv;
		logic [7:0] pat_v;
		logic [7:0] pat_v_inv;
		logic [7:0] white_level;
		logic [7:0] black_level;
	} slgd_in_t;

	typedef struct packed {
		logic [7:0]        direct_light;
		logic [7:0]        global_light;
		logic [CODE_W-1:0] code_h;
		logic [CODE_W-1:0] index_h;
		logic              bad_h;
		logic [CODE_W-1:0] code_v;
		logic [CODE_W-1:0] index_v;
		logic              bad_v;
	} slgd_out_t;

	typedef struct packed {
		logic [LIGHT_W-1:0] ld;
		logic [LIGHT_W-1:0] lg;
		logic [LIGHT_W-1:0] e;
	} slgd_lvl_t;

	typedef struct packed {
		logic lit;
		logic bad;
	} slgd_cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LD,
		ST_LG,
		ST_WALK
	} slgd_state_t;

endpackage

[rtl/slgd_lane.sv]
// ----------------------------------------------------------------------------
// slgd_lane
// Classifies one plane sample pair as lit, unlit or invalid.
// ----------------------------------------------------------------------------
module slgd_lane (
	input  slgd_pkg::slgd_lvl_t lvl,
	input  logic [7:0]          p,
	input  logic [7:0]          q,
	output slgd_pkg::slgd_cls_t cls
);
	import slgd_pkg::*;

	logic [LIGHT_W:0] pw, qw, ldw, lgw, ew;
	logic dom;

	always_comb begin
		pw  = {{(LIGHT_W-15){1'b0}}, p, 8'd0};
		qw  = {{(LIGHT_W-15){1'b0}}, q, 8'd0};
		ldw = {1'b0, lvl.ld};
		lgw = {1'b0, lvl.lg};
		ew  = {1'b0, lvl.e};
		dom = ldw > lgw + ew;
		cls.bad = 1'b0;
		cls.lit = 1'b0;
		if (dom && pw > qw + ew) begin
			cls.lit = 1'b1;
		end else if (dom && pw + ew < qw) begin
			cls.lit = 1'b0;
		end else if (pw + ew < ldw && qw > lgw + ew) begin
			cls.lit = 1'b0;
		end else if (pw > lgw + ew && qw + ew < ldw) begin
			cls.lit = 1'b1;
		end else begin
			cls.bad = 1'b1;
		end
	end

endmodule

[rtl/slgd_div.sv]
// ----------------------------------------------------------------------------
// slgd_div
// Restoring divider giving a Q1.16 quotient for the scale, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slgd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [7:0]  white,
	input  logic [8:0]  sum,
	output logic        done,
	output logic [16:0] quot
);
	import slgd_pkg::*;

	logic [9:0]  rem_q;
	logic [24:0] num_q;
	logic [16:0] quot_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [9:0]  trial;

	assign trial = {rem_q[8:0], num_q[24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 5'd25;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= '0;
			num_q  <= {1'b0, white, 16'd0};
			quot_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[23:0], 1'b0};
			if (trial >= {1'b0, sum}) begin
				rem_q  <= trial - {1'b0, sum};
				quot_q <= {quot_q[15:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[15:0], 1'b0};
			end
		end
	end

	assign quot = quot_q;

endmodule

[rtl/structured_light_gray_decode.sv]
// ----------------------------------------------------------------------------
// structured_light_gray_decode
// Gray-code structured-light decoder with direct and global light split.
// ----------------------------------------------------------------------------
// A pixel arrives as PLANES beats on the in port, lowest plane (code bit 0)
// first, taken when start is high and busy is low. The first beat carries
// the white and black samples. Configuration writes use cfg_we, cfg_idx and
// cfg_data. Each beat but the last is stored without raising busy. After the
// last beat the block raises busy while a restoring divider forms the scale,
// the ST_LD and ST_LG states form direct and global light, and one lane per
// direction walks the planes, one plane per cycle. The result appears on out
// with done high for a single cycle, and busy falls in that same cycle. A
// new pixel is not taken until busy falls, so pixels do not overlap. The
// receiver cannot stall: every result is taken in its strobe cycle. Reset
// clears the plane counter, the sequencer and the configuration registers to
// their defaults; the plane store is not cleared.
// ----------------------------------------------------------------------------
module structured_light_gray_decode #(
	parameter int unsigned PLANES      = 10,
	parameter int unsigned PEAK_PLANES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  slgd_pkg::slgd_in_t   in,
	output logic                 done,
	output slgd_pkg::slgd_out_t  out,
	input  logic                 cfg_we,
	input  logic                 cfg_idx,
	input  logic [7:0]           cfg_data
);
	import slgd_pkg::*;

	localparam int unsigned PEAK = (PEAK_PLANES < PLANES) ? PEAK_PLANES : PLANES;
	localparam int unsigned CW   = $clog2(PLANES);
	localparam int unsigned CWIDE = (PLANES > CODE_W) ? PLANES : CODE_W;

	logic [31:0]   store_q [PLANES];
	logic [CW-1:0] cnt_q;
	logic [7:0]    white_q, black_q;
	logic [7:0]    hi_q, lo_q;
	logic [7:0]    margin_q, mind_q;
	slgd_state_t   st_q, st_d;
	logic          acc, last;
	logic [CW-1:0] wk_q;
	logic [CWIDE-1:0] ch_q, cv_q;
	logic          sh_q, sv_q, bh_q, bv_q;
	logic [16:0]   quot;
	logic [15:0]   binv_q;
	logic          div_go, div_done;
	logic [LIGHT_W-1:0] ld_q, lg_q;
	logic [23:0]   prod_ld;
	logic [31:0]   prod_lg;
	slgd_lvl_t     lvl;
	slgd_cls_t     cls_h, cls_v;
	logic [31:0]   wcur;
	logic [7:0]    bmx, bmn;
	logic          zero_q, faint;
	logic [CWIDE-1:0] ghw, gvw, ihw, ivw;

	assign acc  = start && !busy;
	assign last = acc && (cnt_q == CW'(PLANES - 1));
	assign busy = (st_q != ST_IDLE);

	always_comb begin
		bmx = in.pat_h;
		bmn = in.pat_h;
		if (in.pat_h_inv > bmx) bmx = in.pat_h_inv;
		if (in.pat_v > bmx) bmx = in.pat_v;
		if (in.pat_v_inv > bmx) bmx = in.pat_v_inv;
		if (in.pat_h_inv < bmn) bmn = in.pat_h_inv;
		if (in.pat_v < bmn) bmn = in.pat_v;
		if (in.pat_v_inv < bmn) bmn = in.pat_v_inv;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			store_q[cnt_q] <= {in.pat_v_inv, in.pat_v, in.pat_h_inv, in.pat_h};
			if (cnt_q == '0) begin
				white_q <= in.white_level;
				black_q <= in.black_level;
				hi_q    <= bmx;
				lo_q    <= bmn;
			end else if ({1'b0, cnt_q} < (CW+1)'(PEAK)) begin
				if (bmx > hi_q) hi_q <= bmx;
				if (bmn < lo_q) lo_q <= bmn;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			margin_q <= LIT_MARGIN_RST;
			mind_q   <= MIN_DIRECT_RST;
		end else begin
			if (acc) cnt_q <= last ? '0 : cnt_q + CW'(1);
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_LIT_MARGIN: margin_q <= cfg_data;
					REG_MIN_DIRECT: mind_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign div_go = last;

	slgd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go),
		.white (white_q),
		.sum   ({1'b0, white_q} + {1'b0, black_q}),
		.done  (div_done),
		.quot  (quot)
	);

	assign prod_ld = ({16'd0, hi_q - lo_q} * {8'd0, binv_q});
	assign prod_lg = ({16'd0, hi_q, 8'd0} - {16'd0, ld_q[15:0]}) * {16'd0, binv_q};

	assign lvl    = '{ld: ld_q, lg: lg_q, e: {4'd0, margin_q, 8'd0}};
	assign wcur   = store_q[wk_q];
	assign faint  = ld_q < {4'd0, mind_q, 8'd0};

	slgd_lane u_lane_h (.lvl(lvl), .p(wcur[7:0]),   .q(wcur[15:8]),  .cls(cls_h));
	slgd_lane u_lane_v (.lvl(lvl), .p(wcur[23:16]), .q(wcur[31:24]), .cls(cls_v));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (last) st_d = ST_DIV;
			ST_DIV:  if (div_done) st_d = ST_LD;
			ST_LD:   st_d = ST_LG;
			ST_LG:   st_d = ST_WALK;
			ST_WALK: if (wk_q == CW'(PLANES - 1)) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == ST_WALK) && (wk_q == CW'(PLANES - 1));
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_DIV: begin
				binv_q <= quot[16] ? 16'hFFFF : quot[15:0];
				zero_q <= ({1'b0, white_q} + {1'b0, black_q}) == 9'd0;
			end
			ST_LD: begin
				ld_q <= zero_q ? '0 : {4'd0, prod_ld[23:8]};
			end
			ST_LG: begin
				lg_q <= zero_q ? '0 : {3'd0, prod_lg[31:16], 1'b0};
				wk_q <= '0;
				ch_q <= '0;
				cv_q <= '0;
				sh_q <= 1'b0;
				sv_q <= 1'b0;
				bh_q <= 1'b0;
				bv_q <= 1'b0;
			end
			ST_WALK: begin
				wk_q <= wk_q + CW'(1);
				if (!sh_q) begin
					if (cls_h.bad) begin
						sh_q <= 1'b1;
						bh_q <= 1'b1;
					end else if (cls_h.lit) begin
						ch_q[wk_q] <= 1'b1;
					end
				end
				if (!sv_q) begin
					if (cls_v.bad) begin
						sv_q <= 1'b1;
						bv_q <= 1'b1;
					end else if (cls_v.lit) begin
						cv_q[wk_q] <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	function automatic logic [CWIDE-1:0] g2b(input logic [CWIDE-1:0] g);
		logic [CWIDE-1:0] b;
		b[CWIDE-1] = g[CWIDE-1];
		for (int i = CWIDE - 2; i >= 0; i--) b[i] = b[i+1] ^ g[i];
		return b;
	endfunction

	assign ghw = (zero_q || faint) ? '0 : ch_q;
	assign gvw = (zero_q || faint) ? '0 : cv_q;
	assign ihw = g2b(ghw);
	assign ivw = g2b(gvw);

	always_comb begin
		out.direct_light = (ld_q[LIGHT_W-1:16] != '0) ? 8'hFF : ld_q[15:8];
		out.global_light = (lg_q[LIGHT_W-1:16] != '0) ? 8'hFF : lg_q[15:8];
		out.code_h  = ghw[CODE_W-1:0];
		out.index_h = ihw[CODE_W-1:0];
		out.bad_h   = zero_q || faint || bh_q;
		out.code_v  = gvw[CODE_W-1:0];
		out.index_v = ivw[CODE_W-1:0];
		out.bad_v   = zero_q || faint || bv_q;
	end

endmodule
